// File: design/mcbm_pkg.sv
package mcbm_pkg;

    // field widths
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int LOW_BANK_W  = 7;
    localparam int HIGH_BANK_W = 8;
    localparam int RAM_BANK_W  = 2;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // result field positions in m_tdata
    localparam int LOW_LSB   = 0;
    localparam int HIGH_LSB  = LOW_LSB + LOW_BANK_W;
    localparam int RAMB_LSB  = HIGH_LSB + HIGH_BANK_W;
    localparam int RAMEN_BIT = RAMB_LSB + RAM_BANK_W;
    localparam int MEMWR_BIT = RAMEN_BIT + 1;
    localparam int M_USED_W  = MEMWR_BIT + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANKING_ON = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_MAX   = 2'd2;

    // address regions, by the top three address bits
    localparam logic [2:0] REGION_ENABLE   = 3'b000;
    localparam logic [2:0] REGION_ROM_BANK = 3'b001;
    localparam logic [2:0] REGION_RAM_BANK = 3'b010;
    localparam logic [2:0] REGION_MODE     = 3'b011;

    localparam logic [ADDR_W-1:0] GAME_SELECT_ADDR = 16'hA100;

    // data decode constants
    localparam logic [DATA_W-1:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [DATA_W-1:0] UNLOCK_KEY     = 8'hC0;
    localparam logic [DATA_W-1:0] SEL_GAME_A     = 8'h01;
    localparam logic [DATA_W-1:0] SEL_DONE       = 8'hC0;

    localparam logic [LOW_BANK_W-1:0] OFFSET_GAME_A = 7'd2;
    localparam logic [LOW_BANK_W-1:0] OFFSET_OTHER  = 7'd66;

    localparam logic [HIGH_BANK_W-1:0] UPPER_BANK_RESET = 8'd1;
    localparam logic [HIGH_BANK_W-1:0] ROM_MASK_RESET   = 8'hFF;
    localparam logic [RAM_BANK_W-1:0]  RAM_MAX_RESET    = 2'd3;

endpackage

// File: design/multicart_bank_mapper.sv
// multicart bank mapper: one cpu write beat in, one mapping beat out
// an accepted beat's result is on m_* in the next cycle; one beat per cycle
// unless m_tready stalls the output; the bank registers update in the accept cycle
// the output register frees s_tready whenever its beat is taken or empty
// reset (aresetn low, synchronous): banks return to their power-up mapping,
// config registers to their defaults, and no result beat is pending
module multicart_bank_mapper (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // config write port
    input  logic                                    cfg_we,
    input  logic [mcbm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mcbm_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // input channel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [mcbm_pkg::S_TDATA_W-1:0]          s_tdata,  // address[15:0], data[23:16]
    // result channel
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // low_bank[6:0], high_bank[14:7], ram_bank_out[16:15], ram_enabled[17],
    // mem_write[18], zero[23:19]
    output logic [mcbm_pkg::M_TDATA_W-1:0]          m_tdata
);

    // config registers
    logic [mcbm_pkg::HIGH_BANK_W-1:0] rom_bank_mask_reg;
    logic                             ram_banking_on_reg;
    logic [mcbm_pkg::RAM_BANK_W-1:0]  ram_bank_max_reg;

    // mapper state
    logic                             ram_enable_reg, ram_enable_next;
    logic                             unlock_reg, unlock_next;
    logic [mcbm_pkg::LOW_BANK_W-1:0]  game_offset_reg, game_offset_next;
    logic                             select_done_reg, select_done_next;
    logic [mcbm_pkg::HIGH_BANK_W-1:0] upper_bank_reg, upper_bank_next;
    logic [mcbm_pkg::RAM_BANK_W-1:0]  ram_bank_reg, ram_bank_next;

    // output stage
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [mcbm_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                             in_beat;
    logic [mcbm_pkg::ADDR_W-1:0]      addr;
    logic [mcbm_pkg::DATA_W-1:0]      data;
    logic                             mem_write;
    logic [mcbm_pkg::LOW_BANK_W-1:0]  rom_sel;
    logic [mcbm_pkg::HIGH_BANK_W-1:0] rom_sum;
    logic [mcbm_pkg::RAM_BANK_W-1:0]  ram_sel;

    assign addr     = s_tdata[mcbm_pkg::ADDR_W-1:0];
    assign data     = s_tdata[mcbm_pkg::ADDR_W +: mcbm_pkg::DATA_W];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // rom bank select: zero maps to one, then add the game offset and mask
    always_comb begin
        rom_sel = data[mcbm_pkg::LOW_BANK_W-1:0];
        if (rom_sel == '0) begin
            rom_sel = mcbm_pkg::LOW_BANK_W'(1);
        end
        rom_sum = ({1'b0, rom_sel} + {1'b0, game_offset_reg}) & rom_bank_mask_reg;
    end

    // ram bank select, clamped to the highest bank
    always_comb begin
        ram_sel = data[mcbm_pkg::RAM_BANK_W-1:0];
        if (ram_sel > ram_bank_max_reg) begin
            ram_sel = ram_bank_max_reg;
        end
    end

    // decode one write beat
    always_comb begin
        ram_enable_next  = ram_enable_reg;
        unlock_next      = unlock_reg;
        game_offset_next = game_offset_reg;
        select_done_next = select_done_reg;
        upper_bank_next  = upper_bank_reg;
        ram_bank_next    = ram_bank_reg;
        mem_write        = 1'b0;
        case (addr[mcbm_pkg::ADDR_W-1 -: 3])
            mcbm_pkg::REGION_ENABLE: begin
                ram_enable_next = (data & mcbm_pkg::RAM_ENABLE_KEY) == mcbm_pkg::RAM_ENABLE_KEY;
                unlock_next     = (data & mcbm_pkg::UNLOCK_KEY) == mcbm_pkg::UNLOCK_KEY;
            end
            mcbm_pkg::REGION_ROM_BANK: begin
                upper_bank_next = rom_sum;
            end
            mcbm_pkg::REGION_RAM_BANK: begin
                if (ram_banking_on_reg) begin
                    ram_bank_next = ram_sel;
                end
            end
            mcbm_pkg::REGION_MODE: begin
                // no effect
            end
            default: begin
                if (addr == mcbm_pkg::GAME_SELECT_ADDR && unlock_reg && !select_done_reg) begin
                    if (data == mcbm_pkg::SEL_GAME_A) begin
                        game_offset_next = mcbm_pkg::OFFSET_GAME_A;
                    end else if (data != mcbm_pkg::SEL_DONE) begin
                        game_offset_next = mcbm_pkg::OFFSET_OTHER;
                    end else begin
                        select_done_next = 1'b1;
                    end
                    upper_bank_next = {1'b0, game_offset_next} + mcbm_pkg::HIGH_BANK_W'(1);
                end else begin
                    mem_write = 1'b1;
                end
            end
        endcase
    end

    // result beat and output handshake
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (in_beat) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {
                (mcbm_pkg::M_TDATA_W - mcbm_pkg::M_USED_W)'(0),
                mem_write,
                ram_enable_next,
                ram_bank_next,
                upper_bank_next,
                game_offset_next
            };
        end
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_mask_reg  <= mcbm_pkg::ROM_MASK_RESET;
            ram_banking_on_reg <= 1'b0;
            ram_bank_max_reg   <= mcbm_pkg::RAM_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                mcbm_pkg::CFG_ROM_BANK_MASK: begin
                    rom_bank_mask_reg <= cfg_wdata[mcbm_pkg::HIGH_BANK_W-1:0];
                end
                mcbm_pkg::CFG_RAM_BANKING_ON: begin
                    ram_banking_on_reg <= cfg_wdata[0];
                end
                mcbm_pkg::CFG_RAM_BANK_MAX: begin
                    ram_bank_max_reg <= cfg_wdata[mcbm_pkg::RAM_BANK_W-1:0];
                end
                default: begin
                    // unused index
                end
            endcase
        end
    end

    // mapper state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ram_enable_reg  <= 1'b0;
            unlock_reg      <= 1'b0;
            game_offset_reg <= '0;
            select_done_reg <= 1'b0;
            upper_bank_reg  <= mcbm_pkg::UPPER_BANK_RESET;
            ram_bank_reg    <= '0;
        end else if (in_beat) begin
            ram_enable_reg  <= ram_enable_next;
            unlock_reg      <= unlock_next;
            game_offset_reg <= game_offset_next;
            select_done_reg <= select_done_next;
            upper_bank_reg  <= upper_bank_next;
            ram_bank_reg    <= ram_bank_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: design/mcbm_checker.sv
module mcbm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [mcbm_pkg::S_TDATA_W-1:0]      s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mcbm_pkg::M_TDATA_W-1:0]      m_tdata
);

    logic [mcbm_pkg::LOW_BANK_W-1:0] low_bank;

    assign low_bank = m_tdata[mcbm_pkg::LOW_LSB +: mcbm_pkg::LOW_BANK_W];

    // no result beat pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat pending after reset");

    // an empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // every accepted beat gives a result beat in the next cycle
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");

    // writes below the memory window never pass through
    a_no_mem_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tdata[mcbm_pkg::ADDR_W-1])
            |=> !m_tdata[mcbm_pkg::MEMWR_BIT])
        else $error("register write flagged as memory write");

    // game offset is only ever one of the selectable values
    a_offset_values: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (low_bank == '0 || low_bank == mcbm_pkg::OFFSET_GAME_A
                      || low_bank == mcbm_pkg::OFFSET_OTHER))
        else $error("unexpected game offset");

endmodule

bind multicart_bank_mapper mcbm_checker u_mcbm_checker (.*);
